### hdl/mrbb_pkg.sv
// Shared types and constants for the multi-ring byte buffer.
package mrbb_pkg;

	localparam int DEF_RING_SLOTS = 4;
	localparam int DEF_RING_BYTES = 1024;
	localparam int DEF_MAX_GET    = 64;

	localparam int COUNT_W     = 7;
	localparam int RES_COUNT_W = 11;

	typedef enum logic [2:0] {
		ACT_ALLOC   = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_POST    = 3'd2,
		ACT_GET     = 3'd3,
		ACT_PULL    = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_FREE   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_OVER_PULL = 3'd4,
		ST_NOT_ALLOC = 3'd5,
		ST_DROPPED   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ROOM_EMPTY  = 2'd0,
		ROOM_NORMAL = 2'd1,
		ROOM_FULL   = 2'd2
	} room_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_GET  = 2'd2
	} state_t;

endpackage

### hdl/mrbb_ram.sv
// Single-port synchronous RAM, registered read, write takes priority.
module mrbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/multi_ring_byte_buffer_peek_commit_unit.sv
// Top level of the multi-ring byte buffer with peek and commit.
//
// Allocate, release, post and pull each read the ring descriptor from the
// descriptor RAM in the cycle the transaction is accepted and write it back
// in the next. A get reads the descriptor the same way and then does one
// byte-store read per delivered byte. busy is high while a transaction is in work. Each
// result shows on the result ports, marked by res_valid, for exactly one cycle,
// in the cycle after it is produced; the receiver cannot stall, and a new
// transaction can be started while the previous result is on the ports.
module multi_ring_byte_buffer_peek_commit_unit #(
	parameter int RING_SLOTS = mrbb_pkg::DEF_RING_SLOTS,
	parameter int RING_BYTES = mrbb_pkg::DEF_RING_BYTES,
	parameter int MAX_GET    = mrbb_pkg::DEF_MAX_GET
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [2:0]                           action,
	input  logic [1:0]                           ring_id,
	input  logic [7:0]                           data_byte,
	input  logic [mrbb_pkg::COUNT_W-1:0]         count,
	input  logic                                 last,
	output logic                                 res_valid,
	output logic [2:0]                           status,
	output logic [1:0]                           ring_id_res,
	output logic [7:0]                           data_byte_res,
	output logic [mrbb_pkg::RES_COUNT_W-1:0]     count_res,
	output logic [1:0]                           room_state,
	output logic                                 last_res
);

	localparam int SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int PW = $clog2(RING_BYTES);
	localparam int UW = $clog2(RING_BYTES + 1);
	localparam int TOTAL = RING_SLOTS * RING_BYTES;
	localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int GW = mrbb_pkg::COUNT_W;
	localparam int CW = mrbb_pkg::RES_COUNT_W;
	localparam int DW = 2 * PW + UW + 1 + GW;

	mrbb_pkg::state_t  state_q, state_d;
	mrbb_pkg::action_t act_q;
	logic [1:0]        rid_q;
	logic [7:0]        data_q;
	logic [GW-1:0]     count_q;
	logic              last_q;

	logic [RING_SLOTS-1:0] slot_busy_q, slot_busy_d;
	logic [CW-1:0]         burst_q, burst_d;

	logic [GW-1:0] get_n_q, get_n_d;
	logic [GW-1:0] get_idx_q, get_idx_d;
	logic [PW-1:0] get_ptr_q, get_ptr_d;
	logic [SW-1:0] get_slot_q, get_slot_d;
	logic [1:0]    get_room_q, get_room_d;

	logic          res_valid_q, res_valid_d;
	logic [2:0]    res_status_q, res_status_d;
	logic [1:0]    res_rid_q, res_rid_d;
	logic [CW-1:0] res_count_q, res_count_d;
	logic [1:0]    res_room_q, res_room_d;
	logic          res_last_q, res_last_d;
	logic          res_mem_q, res_mem_d;

	logic          desc_we;
	logic [SW-1:0] desc_addr;
	logic [SW-1:0] desc_wslot;
	logic [DW-1:0] desc_wdata;
	logic [DW-1:0] desc_rdata;

	logic          byte_we;
	logic [SW-1:0] byte_slot;
	logic [PW-1:0] byte_ptr;
	logic [AW-1:0] byte_addr;
	logic [7:0]    byte_rdata;

	logic [SW-1:0] rid_slot;
	logic          rid_valid;
	logic [PW-1:0] d_wr, d_head;
	logic [UW-1:0] d_used;
	logic          d_await;
	logic [GW-1:0] d_peek;

	logic [SW-1:0] free_slot;
	logic          free_found;

	function automatic logic [1:0] room_of(input logic [UW-1:0] used);
		if (used == '0) begin
			return mrbb_pkg::ROOM_EMPTY;
		end else if (int'(used) >= RING_BYTES) begin
			return mrbb_pkg::ROOM_FULL;
		end
		return mrbb_pkg::ROOM_NORMAL;
	endfunction

	assign rid_slot  = SW'(rid_q);
	assign rid_valid = (int'(rid_q) < RING_SLOTS) && slot_busy_q[rid_slot];
	assign {d_wr, d_head, d_used, d_await, d_peek} = desc_rdata;

	always_comb begin
		free_slot  = '0;
		free_found = 1'b0;
		for (int s = RING_SLOTS - 1; s >= 0; s--) begin
			if (!slot_busy_q[s]) begin
				free_slot  = SW'(s);
				free_found = 1'b1;
			end
		end
	end

	assign desc_addr = (state_q == mrbb_pkg::S_IDLE) ? SW'(ring_id) : desc_wslot;
	assign byte_addr = AW'(byte_slot) * AW'(RING_BYTES) + AW'(byte_ptr);

	mrbb_ram #(
		.WIDTH(DW),
		.DEPTH(RING_SLOTS)
	) u_desc_ram (
		.clk  (clk),
		.we   (desc_we),
		.addr (desc_addr),
		.wdata(desc_wdata),
		.rdata(desc_rdata)
	);

	mrbb_ram #(
		.WIDTH(8),
		.DEPTH(TOTAL)
	) u_byte_ram (
		.clk  (clk),
		.we   (byte_we),
		.addr (byte_addr),
		.wdata(data_q),
		.rdata(byte_rdata)
	);

	always_comb begin
		logic [GW-1:0] n;
		logic [PW:0]   head_sum;
		logic [PW-1:0] new_head;
		logic [PW-1:0] new_wr;
		logic [UW-1:0] new_used;
		logic          get_last;

		state_d      = state_q;
		slot_busy_d  = slot_busy_q;
		burst_d      = burst_q;
		get_n_d      = get_n_q;
		get_idx_d    = get_idx_q;
		get_ptr_d    = get_ptr_q;
		get_slot_d   = get_slot_q;
		get_room_d   = get_room_q;
		res_valid_d  = 1'b0;
		res_status_d = mrbb_pkg::ST_OK;
		res_rid_d    = rid_q;
		res_count_d  = '0;
		res_room_d   = mrbb_pkg::ROOM_EMPTY;
		res_last_d   = 1'b1;
		res_mem_d    = 1'b0;
		desc_we      = 1'b0;
		desc_wslot   = rid_slot;
		desc_wdata   = desc_rdata;
		byte_we      = 1'b0;
		byte_slot    = rid_slot;
		byte_ptr     = d_wr;

		n        = (int'(count_q) > MAX_GET) ? GW'(MAX_GET) : count_q;
		head_sum = {1'b0, d_head} + (PW + 1)'(count_q);
		new_head = (int'(head_sum) >= RING_BYTES) ? PW'(int'(head_sum) - RING_BYTES)
			: PW'(head_sum);
		new_wr   = (int'(d_wr) == RING_BYTES - 1) ? '0 : d_wr + PW'(1);
		new_used = d_used;
		get_last = (get_idx_q + GW'(1)) == get_n_q;

		case (state_q)
			mrbb_pkg::S_IDLE: begin
				if (start) begin
					state_d = mrbb_pkg::S_EXEC;
				end
			end
			mrbb_pkg::S_EXEC: begin
				state_d = mrbb_pkg::S_IDLE;
				case (act_q)
					mrbb_pkg::ACT_ALLOC: begin
						res_valid_d = 1'b1;
						if (free_found) begin
							slot_busy_d[free_slot] = 1'b1;
							desc_we     = 1'b1;
							desc_wslot  = free_slot;
							desc_wdata  = '0;
							res_rid_d   = 2'(free_slot);
						end else begin
							res_status_d = mrbb_pkg::ST_NO_FREE;
							res_rid_d    = 2'd0;
						end
					end
					mrbb_pkg::ACT_RELEASE: begin
						res_valid_d = 1'b1;
						if (rid_valid) begin
							slot_busy_d[rid_slot] = 1'b0;
						end else begin
							res_status_d = mrbb_pkg::ST_NOT_ALLOC;
						end
					end
					mrbb_pkg::ACT_POST: begin
						res_valid_d = 1'b1;
						res_count_d = burst_q;
						if (!rid_valid) begin
							res_status_d = mrbb_pkg::ST_NOT_ALLOC;
						end else if (int'(d_used) >= RING_BYTES) begin
							res_status_d = mrbb_pkg::ST_DROPPED;
							res_room_d   = room_of(d_used);
						end else begin
							new_used    = d_used + UW'(1);
							byte_we     = 1'b1;
							desc_we     = 1'b1;
							desc_wdata  = {new_wr, d_head, new_used, d_await, d_peek};
							if (burst_q != {CW{1'b1}}) begin
								res_count_d = burst_q + CW'(1);
							end
							res_room_d  = room_of(new_used);
						end
						burst_d = last_q ? '0 : res_count_d;
					end
					mrbb_pkg::ACT_GET: begin
						if (int'(d_used) < int'(n)) begin
							n = GW'(d_used);
						end
						if (!rid_valid) begin
							res_valid_d  = 1'b1;
							res_status_d = mrbb_pkg::ST_NOT_ALLOC;
						end else if (d_await) begin
							res_valid_d  = 1'b1;
							res_status_d = mrbb_pkg::ST_MISMATCH;
							res_room_d   = room_of(d_used);
						end else if (d_used == '0) begin
							res_valid_d  = 1'b1;
							res_status_d = mrbb_pkg::ST_EMPTY;
						end else begin
							desc_we    = 1'b1;
							desc_wdata = {d_wr, d_head, d_used, 1'b1, n};
							if (n == '0) begin
								res_valid_d = 1'b1;
								res_room_d  = room_of(d_used);
							end else begin
								state_d    = mrbb_pkg::S_GET;
								get_n_d    = n;
								get_idx_d  = '0;
								get_ptr_d  = d_head;
								get_slot_d = rid_slot;
								get_room_d = room_of(d_used);
							end
						end
					end
					mrbb_pkg::ACT_PULL: begin
						res_valid_d = 1'b1;
						if (!rid_valid) begin
							res_status_d = mrbb_pkg::ST_NOT_ALLOC;
						end else if (!d_await) begin
							res_status_d = mrbb_pkg::ST_MISMATCH;
							res_room_d   = room_of(d_used);
						end else if (count_q > d_peek) begin
							res_status_d = mrbb_pkg::ST_OVER_PULL;
							res_room_d   = room_of(d_used);
						end else begin
							new_used    = d_used - UW'(count_q);
							desc_we     = 1'b1;
							desc_wdata  = {d_wr, new_head, new_used, 1'b0, GW'(0)};
							res_count_d = CW'(count_q);
							res_room_d  = room_of(new_used);
						end
					end
					default: begin
					end
				endcase
			end
			mrbb_pkg::S_GET: begin
				byte_slot   = get_slot_q;
				byte_ptr    = get_ptr_q;
				res_valid_d = 1'b1;
				res_mem_d   = 1'b1;
				res_count_d = CW'(get_n_q);
				res_room_d  = get_room_q;
				res_last_d  = get_last;
				get_idx_d   = get_idx_q + GW'(1);
				get_ptr_d   = (int'(get_ptr_q) == RING_BYTES - 1) ? '0 : get_ptr_q + PW'(1);
				if (get_last) begin
					state_d = mrbb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mrbb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrbb_pkg::S_IDLE;
			slot_busy_q <= '0;
			burst_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			slot_busy_q <= slot_busy_d;
			burst_q     <= burst_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mrbb_pkg::S_IDLE && start) begin
			act_q   <= mrbb_pkg::action_t'(action);
			rid_q   <= ring_id;
			data_q  <= data_byte;
			count_q <= count;
			last_q  <= last;
		end
		get_n_q      <= get_n_d;
		get_idx_q    <= get_idx_d;
		get_ptr_q    <= get_ptr_d;
		get_slot_q   <= get_slot_d;
		get_room_q   <= get_room_d;
		res_status_q <= res_status_d;
		res_rid_q    <= res_rid_d;
		res_count_q  <= res_count_d;
		res_room_q   <= res_room_d;
		res_last_q   <= res_last_d;
		res_mem_q    <= res_mem_d;
	end

	assign busy          = (state_q != mrbb_pkg::S_IDLE);
	assign res_valid     = res_valid_q;
	assign status        = res_status_q;
	assign ring_id_res   = res_rid_q;
	assign data_byte_res = res_mem_q ? byte_rdata : 8'd0;
	assign count_res     = res_count_q;
	assign room_state    = res_room_q;
	assign last_res      = res_last_q;

	a_get_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last_res |=> res_valid)
		else $error("get transaction results not contiguous");

	a_accept_takes_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not occupy the unit");

	a_drop_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == mrbb_pkg::ST_DROPPED |-> room_state == mrbb_pkg::ROOM_FULL)
		else $error("byte dropped on a ring that is not full");

endmodule

### sim/mrbb_checker.sv
`timescale 1ns / 1ps
// Checker for the multi-ring byte buffer: predicts every result and compares it.
module mrbb_checker
	import mrbb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [2:0]             action,
	input  logic [1:0]             ring_id,
	input  logic [7:0]             data_byte,
	input  logic [COUNT_W-1:0]     count,
	input  logic                   last,
	input  logic                   res_valid,
	input  logic [2:0]             status,
	input  logic [1:0]             ring_id_res,
	input  logic [7:0]             data_byte_res,
	input  logic [RES_COUNT_W-1:0] count_res,
	input  logic [1:0]             room_state,
	input  logic                   last_res,
	output int                     errors,
	output int                     pending
);

	localparam int SLOTS   = DEF_RING_SLOTS;
	localparam int BYTES   = DEF_RING_BYTES;
	localparam int GET_CAP = DEF_MAX_GET;
	localparam int PTR_W   = $clog2(BYTES);

	typedef struct {
		status_t                status;
		logic [1:0]             ring;
		logic [7:0]             data;
		logic [RES_COUNT_W-1:0] tally;
		room_t                  room;
		logic                   fin;
	} ring_reply_t;

	ring_reply_t due_replies[$];

	logic                   ring_live [SLOTS];
	logic [PTR_W-1:0]       wr_ptr    [SLOTS];
	logic [PTR_W-1:0]       head_ptr  [SLOTS];
	logic [RES_COUNT_W-1:0] fill      [SLOTS];
	logic                   peek_open [SLOTS];
	logic [COUNT_W-1:0]     peek_n    [SLOTS];
	logic [RES_COUNT_W-1:0] burst_tally;
	logic [7:0]             byte_mem  [SLOTS*BYTES];

	function automatic room_t room_for(int r);
		if (!ring_live[r] || fill[r] == 0)
			return ROOM_EMPTY;
		if (fill[r] >= BYTES)
			return ROOM_FULL;
		return ROOM_NORMAL;
	endfunction

	function automatic void push_reply(status_t st, logic [1:0] ring, logic [7:0] d,
			logic [RES_COUNT_W-1:0] t, room_t rm, logic fin);
		ring_reply_t rep;
		rep.status = st;
		rep.ring   = ring;
		rep.data   = d;
		rep.tally  = t;
		rep.room   = rm;
		rep.fin    = fin;
		due_replies.push_back(rep);
	endfunction

	function automatic void run_ring_command(logic [2:0] act, logic [1:0] rid, logic [7:0] din,
			logic [COUNT_W-1:0] cnt, logic burst_end);
		int r;
		int s;
		int n;
		int i;
		logic ok;
		status_t st;
		r  = rid;
		ok = ring_live[r];

		if (act == ACT_ALLOC) begin
			s = 0;
			while (s < SLOTS && ring_live[s])
				s++;
			if (s == SLOTS) begin
				push_reply(ST_NO_FREE, 2'd0, 8'd0, '0, ROOM_EMPTY, 1'b1);
			end else begin
				ring_live[s] = 1'b1;
				wr_ptr[s]    = '0;
				head_ptr[s]  = '0;
				fill[s]      = '0;
				peek_open[s] = 1'b0;
				peek_n[s]    = '0;
				push_reply(ST_OK, 2'(s), 8'd0, '0, ROOM_EMPTY, 1'b1);
			end
			return;
		end
		if (act > ACT_PULL)
			return;

		if (act == ACT_POST) begin
			if (!ok) begin
				st = ST_NOT_ALLOC;
			end else if (fill[r] >= BYTES) begin
				st = ST_DROPPED;
			end else begin
				byte_mem[r*BYTES + int'(wr_ptr[r])] = din;
				wr_ptr[r] = wr_ptr[r] + 1'b1;
				fill[r]   = fill[r] + 1'b1;
				if (burst_tally != '1)
					burst_tally = burst_tally + 1'b1;
				st = ST_OK;
			end
			push_reply(st, rid, 8'd0, burst_tally, room_for(r), 1'b1);
			if (burst_end)
				burst_tally = '0;
			return;
		end

		if (!ok) begin
			push_reply(ST_NOT_ALLOC, rid, 8'd0, '0, ROOM_EMPTY, 1'b1);
			return;
		end

		if (act == ACT_RELEASE) begin
			ring_live[r] = 1'b0;
			peek_open[r] = 1'b0;
			peek_n[r]    = '0;
			push_reply(ST_OK, rid, 8'd0, '0, ROOM_EMPTY, 1'b1);
			return;
		end

		if (act == ACT_GET) begin
			if (peek_open[r]) begin
				push_reply(ST_MISMATCH, rid, 8'd0, '0, room_for(r), 1'b1);
				return;
			end
			if (fill[r] == 0) begin
				push_reply(ST_EMPTY, rid, 8'd0, '0, ROOM_EMPTY, 1'b1);
				return;
			end
			n = cnt;
			if (n > GET_CAP)
				n = GET_CAP;
			if (n > fill[r])
				n = fill[r];
			peek_open[r] = 1'b1;
			peek_n[r]    = COUNT_W'(n);
			if (n == 0) begin
				push_reply(ST_OK, rid, 8'd0, '0, room_for(r), 1'b1);
				return;
			end
			for (i = 0; i < n; i++)
				push_reply(ST_OK, rid, byte_mem[r*BYTES + (int'(head_ptr[r]) + i) % BYTES],
					RES_COUNT_W'(n), room_for(r), i == n - 1);
			return;
		end

		// pull
		if (!peek_open[r]) begin
			push_reply(ST_MISMATCH, rid, 8'd0, '0, room_for(r), 1'b1);
			return;
		end
		if (cnt > peek_n[r]) begin
			push_reply(ST_OVER_PULL, rid, 8'd0, '0, room_for(r), 1'b1);
			return;
		end
		head_ptr[r]  = head_ptr[r] + PTR_W'(cnt);
		fill[r]      = fill[r] - cnt;
		peek_open[r] = 1'b0;
		peek_n[r]    = '0;
		push_reply(ST_OK, rid, 8'd0, RES_COUNT_W'(cnt), room_for(r), 1'b1);
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_reply_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				ring_live[s] = 1'b0;
				wr_ptr[s]    = '0;
				head_ptr[s]  = '0;
				fill[s]      = '0;
				peek_open[s] = 1'b0;
				peek_n[s]    = '0;
			end
			burst_tally = '0;
			due_replies.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (res_valid) begin
				if (due_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d ring %0d",
						status, ring_id_res));
				end else begin
					want = due_replies.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("ring %0d status got %0d want %0d",
							want.ring, status, want.status));
					if (ring_id_res !== want.ring)
						report_mismatch($sformatf("ring_id_res got %0d want %0d",
							ring_id_res, want.ring));
					if (data_byte_res !== want.data)
						report_mismatch($sformatf("ring %0d data_byte_res got %0h want %0h",
							want.ring, data_byte_res, want.data));
					if (count_res !== want.tally)
						report_mismatch($sformatf("ring %0d count_res got %0d want %0d",
							want.ring, count_res, want.tally));
					if (room_state !== want.room)
						report_mismatch($sformatf("ring %0d room_state got %0d want %0d",
							want.ring, room_state, want.room));
					if (last_res !== want.fin)
						report_mismatch($sformatf("ring %0d last_res got %0d want %0d",
							want.ring, last_res, want.fin));
				end
			end
			if (start && !busy)
				run_ring_command(action, ring_id, data_byte, count, last);
			pending = due_replies.size();
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the multi-ring byte buffer: stimulus, reset, clock and verdict.
module tb;
	import mrbb_pkg::*;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic [2:0]         action    = '0;
	logic [1:0]         ring_id   = '0;
	logic [7:0]         data_byte = '0;
	logic [COUNT_W-1:0] count     = '0;
	logic               last      = 1'b0;

	logic                   busy;
	logic                   res_valid;
	logic [2:0]             status;
	logic [1:0]             ring_id_res;
	logic [7:0]             data_byte_res;
	logic [RES_COUNT_W-1:0] count_res;
	logic [1:0]             room_state;
	logic                   last_res;
	int                     errors;
	int                     pending;

	int         burst_left = 0;
	int         issued     = 0;
	logic [3:0] owned      = '0;

	always #10 clk = ~clk;

	multi_ring_byte_buffer_peek_commit_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.ring_id      (ring_id),
		.data_byte    (data_byte),
		.count        (count),
		.last         (last),
		.res_valid    (res_valid),
		.status       (status),
		.ring_id_res  (ring_id_res),
		.data_byte_res(data_byte_res),
		.count_res    (count_res),
		.room_state   (room_state),
		.last_res     (last_res)
	);

	mrbb_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.ring_id      (ring_id),
		.data_byte    (data_byte),
		.count        (count),
		.last         (last),
		.res_valid    (res_valid),
		.status       (status),
		.ring_id_res  (ring_id_res),
		.data_byte_res(data_byte_res),
		.count_res    (count_res),
		.room_state   (room_state),
		.last_res     (last_res),
		.errors       (errors),
		.pending      (pending)
	);

	// one transaction; bursts of back-to-back starts separated by random gaps
	task automatic issue(logic [2:0] a, logic [1:0] r, logic [7:0] d, logic [COUNT_W-1:0] c,
			logic l);
		int gap;
		int s;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start     <= 1'b1;
		action    <= a;
		ring_id   <= r;
		data_byte <= d;
		count     <= c;
		last      <= l;
		do @(posedge clk); while (busy);
		if (a == ACT_ALLOC) begin
			s = 0;
			while (s < 4 && owned[s])
				s++;
			if (s < 4)
				owned[s] = 1'b1;
		end else if (a == ACT_RELEASE) begin
			owned[r] = 1'b0;
		end
		if (a <= ACT_PULL)
			issued++;
	endtask

	function automatic logic [1:0] pick_ring();
		int k;
		if (owned != 0 && $urandom_range(0, 9) != 0) begin
			do k = $urandom_range(0, 3); while (!owned[k]);
			return 2'(k);
		end
		return 2'($urandom_range(0, 3));
	endfunction

	task automatic post_burst(logic [1:0] r, int len, logic mark_end);
		for (int i = 0; i < len; i++)
			issue(ACT_POST, r, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 64)),
				mark_end && i == len - 1);
	endtask

	initial begin
		int k;
		int c;
		int pc;
		int roll;
		logic [1:0] r;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rings not allocated, allocation to exhaustion, peek/commit errors, undefined actions
		issue(ACT_PULL, 2'd2, 8'd0, 7'd0, 1'b0);
		issue(ACT_GET, 2'd1, 8'd0, 7'd5, 1'b0);
		issue(ACT_RELEASE, 2'd3, 8'd0, 7'd0, 1'b0);
		issue(ACT_POST, 2'd0, 8'hFF, 7'd0, 1'b1);
		repeat (4) issue(ACT_ALLOC, 2'd3, 8'd0, 7'd0, 1'b0);
		issue(ACT_ALLOC, 2'd0, 8'd0, 7'd0, 1'b0);
		issue(ACT_GET, 2'd0, 8'd0, 7'd64, 1'b0);
		issue(ACT_PULL, 2'd0, 8'd0, 7'd0, 1'b0);
		issue(ACT_POST, 2'd0, 8'h00, 7'd0, 1'b0);
		issue(ACT_POST, 2'd1, 8'hFF, 7'd0, 1'b0);
		issue(ACT_POST, 2'd0, 8'hA5, 7'd0, 1'b1);
		issue(ACT_GET, 2'd0, 8'd0, 7'd0, 1'b0);
		issue(ACT_GET, 2'd0, 8'd0, 7'd3, 1'b0);
		issue(ACT_PULL, 2'd0, 8'd0, 7'd1, 1'b0);
		issue(ACT_PULL, 2'd0, 8'd0, 7'd0, 1'b0);
		issue(ACT_GET, 2'd0, 8'd0, 7'd64, 1'b0);
		issue(ACT_PULL, 2'd0, 8'd0, 7'd3, 1'b0);
		issue(ACT_PULL, 2'd0, 8'd0, 7'd2, 1'b0);
		issue(ACT_GET, 2'd1, 8'd0, 7'd1, 1'b0);
		issue(ACT_RELEASE, 2'd1, 8'd0, 7'd0, 1'b0);
		issue(ACT_ALLOC, 2'd0, 8'd0, 7'd0, 1'b0);
		issue(ACT_GET, 2'd1, 8'd0, 7'd1, 1'b0);
		issue(3'd5, 2'd2, 8'h5A, 7'd64, 1'b1);
		issue(3'd6, 2'd1, 8'hC3, 7'd1, 1'b0);
		issue(3'd7, 2'd3, 8'h3C, 7'd0, 1'b1);

		// random: mostly post bursts and get/pull pairs, with allocate, release and noise
		while (issued < 230) begin
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				post_burst(pick_ring(), $urandom_range(1, 10), $urandom_range(0, 9) != 0);
			end else if (roll < 70) begin
				r = pick_ring();
				c = (roll < 55) ? $urandom_range(0, 8) : $urandom_range(0, 64);
				issue(ACT_GET, r, 8'($urandom_range(0, 255)), 7'(c), 1'($urandom_range(0, 1)));
				pc = $urandom_range(0, 9);
				if (pc < 7) begin
					issue(ACT_PULL, r, 8'd0, 7'($urandom_range(0, c)), 1'b0);
				end else if (pc < 9) begin
					c = c + $urandom_range(1, 3);
					issue(ACT_PULL, r, 8'd0, 7'((c > 64) ? 64 : c), 1'b0);
				end
			end else if (roll < 78) begin
				issue(ACT_ALLOC, 2'($urandom_range(0, 3)), 8'd0, 7'd0, 1'b0);
			end else if (roll < 85) begin
				issue(ACT_RELEASE, pick_ring(), 8'd0, 7'd0, 1'b0);
			end else begin
				issue(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)), 7'($urandom_range(0, 64)),
					1'($urandom_range(0, 1)));
			end
		end
		start <= 1'b0;

		k = 0;
		@(negedge clk);
		while (pending != 0 && k < 20000) begin
			@(negedge clk);
			k++;
		end
		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
